// ===== design/gscl_pkg.sv =====
package gscl_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EVENT = 2'd2
  } op_e;

  // Register classes that an offset decodes to.
  typedef enum logic [2:0] {
    REG_FSEL,
    REG_SET,
    REG_CLR,
    REG_LEV,
    REG_UNIMP,
    REG_BAD
  } reg_e;

  // Decoded register access.
  typedef struct packed {
    reg_e       kind;
    logic [2:0] fsel_idx;
    logic       bank;
  } dec_t;

  // Field widths of the beats.
  localparam int unsigned OFS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PIN_W    = 6;
  localparam int unsigned DRIVE_W  = 54;
  localparam int unsigned FN_W     = 3;
  localparam int unsigned BANK_BITS = 32;

  // Function-select layout.
  localparam int unsigned PINS_PER_FSEL = 10;
  localparam int unsigned FSEL_REGS     = 6;
  localparam int unsigned FSEL_PINS     = PINS_PER_FSEL * FSEL_REGS;

  // Function codes.
  localparam logic [FN_W-1:0] FN_INPUT  = 3'd0;
  localparam logic [FN_W-1:0] FN_OUTPUT = 3'd1;

  // Register offsets.
  localparam logic [OFS_W-1:0] OFS_FSEL_END = 8'(FSEL_REGS * 4);
  localparam logic [OFS_W-1:0] OFS_SET0 = 8'h1C;
  localparam logic [OFS_W-1:0] OFS_SET1 = 8'h20;
  localparam logic [OFS_W-1:0] OFS_CLR0 = 8'h28;
  localparam logic [OFS_W-1:0] OFS_CLR1 = 8'h2C;
  localparam logic [OFS_W-1:0] OFS_LEV0 = 8'h34;
  localparam logic [OFS_W-1:0] OFS_LEV1 = 8'h38;

  // Known registers that are not implemented (edge detect, enables, pulls).
  localparam int unsigned UNIMP_COUNT = 17;
  localparam logic [OFS_W-1:0] UNIMP_OFS [UNIMP_COUNT] = '{
    8'h40, 8'h44, 8'h4C, 8'h50, 8'h58, 8'h5C, 8'h64, 8'h68, 8'h70,
    8'h74, 8'h7C, 8'h80, 8'h88, 8'h8C, 8'h94, 8'h98, 8'h9C
  };

endpackage

// ===== design/gscl_if.sv =====
// Request channel: bus accesses and pin events.
interface gscl_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [gscl_pkg::OFS_W-1:0]          offset;
  logic [gscl_pkg::DATA_W-1:0]         write_data;
  logic [gscl_pkg::PIN_W-1:0]          pin_index;
  logic                                pin_value;

  modport source (output valid, op, offset, write_data, pin_index, pin_value,
                  input ready);
  modport sink (input valid, op, offset, write_data, pin_index, pin_value,
                output ready);
endinterface

// Response channel: read data, error flag and pin drive levels.
interface gscl_out_if;
  logic                                valid;
  logic                                ready;
  logic [gscl_pkg::DATA_W-1:0]         read_data;
  logic                                bus_error;
  logic [gscl_pkg::DRIVE_W-1:0]        pin_drive;

  modport source (output valid, read_data, bus_error, pin_drive, input ready);
  modport sink (input valid, read_data, bus_error, pin_drive, output ready);
endinterface

// ===== design/gscl_decode.sv =====
module gscl_decode (
  input  logic [gscl_pkg::OFS_W-1:0] offset_i,
  output gscl_pkg::dec_t             dec_o
);

  logic unimp;

  // Match against the list of unimplemented registers.
  always_comb begin
    unimp = 1'b0;
    for (int i = 0; i < gscl_pkg::UNIMP_COUNT; i++) begin
      if (offset_i == gscl_pkg::UNIMP_OFS[i]) begin
        unimp = 1'b1;
      end
    end
  end

  // Classify the offset; unaligned or reserved words are errors.
  always_comb begin
    dec_o.fsel_idx = offset_i[4:2];
    dec_o.bank     = (offset_i == gscl_pkg::OFS_SET1) || (offset_i == gscl_pkg::OFS_CLR1) ||
                     (offset_i == gscl_pkg::OFS_LEV1);
    case (offset_i) inside
      gscl_pkg::OFS_SET0, gscl_pkg::OFS_SET1: dec_o.kind = gscl_pkg::REG_SET;
      gscl_pkg::OFS_CLR0, gscl_pkg::OFS_CLR1: dec_o.kind = gscl_pkg::REG_CLR;
      gscl_pkg::OFS_LEV0, gscl_pkg::OFS_LEV1: dec_o.kind = gscl_pkg::REG_LEV;
      default: begin
        if ((offset_i < gscl_pkg::OFS_FSEL_END) && (offset_i[1:0] == 2'b00)) begin
          dec_o.kind = gscl_pkg::REG_FSEL;
        end else if (unimp) begin
          dec_o.kind = gscl_pkg::REG_UNIMP;
        end else begin
          dec_o.kind = gscl_pkg::REG_BAD;
        end
      end
    endcase
  end

endmodule

// ===== design/gscl_core.sv =====
module gscl_core #(
  parameter int unsigned PIN_COUNT = 54
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [1:0]                     op_i,
  input  gscl_pkg::dec_t                 dec_i,
  input  logic [gscl_pkg::DATA_W-1:0]    write_data_i,
  input  logic [gscl_pkg::PIN_W-1:0]     pin_index_i,
  input  logic                           pin_value_i,
  output logic [gscl_pkg::DATA_W-1:0]    read_data_o,
  output logic                           bus_error_o,
  output logic [gscl_pkg::DRIVE_W-1:0]   pin_drive_o
);

  localparam int unsigned WideW = 2 * gscl_pkg::BANK_BITS;

  logic [gscl_pkg::FN_W-1:0]   fsel_q [PIN_COUNT];
  logic [gscl_pkg::FN_W-1:0]   fsel_d [PIN_COUNT];
  logic [PIN_COUNT-1:0]        lev_q, lev_d;
  logic [PIN_COUNT-1:0]        drive_q, drive_d;
  logic [PIN_COUNT-1:0]        out_mask, in_mask, pin_hit, val;
  logic [WideW-1:0]            val_wide, lev_wide, drive_wide;
  logic [gscl_pkg::DATA_W-1:0] fsel_word [gscl_pkg::FSEL_REGS];
  logic                        is_wr, is_rd, is_ev, fsel_wr;

  assign is_wr   = (op_i == gscl_pkg::OP_WRITE);
  assign is_rd   = (op_i == gscl_pkg::OP_READ);
  assign is_ev   = (op_i == gscl_pkg::OP_EVENT);
  assign fsel_wr = en_i && is_wr && (dec_i.kind == gscl_pkg::REG_FSEL);

  // Per-pin function masks, event select and function-select update.
  for (genvar g = 0; g < PIN_COUNT; g++) begin : g_pin
    localparam int unsigned Reg = g / gscl_pkg::PINS_PER_FSEL;
    localparam int unsigned Lsb = gscl_pkg::FN_W * (g % gscl_pkg::PINS_PER_FSEL);

    assign out_mask[g] = (fsel_q[g] == gscl_pkg::FN_OUTPUT);
    assign in_mask[g]  = (fsel_q[g] == gscl_pkg::FN_INPUT);
    assign pin_hit[g]  = (pin_index_i == gscl_pkg::PIN_W'(g));

    if (g < gscl_pkg::FSEL_PINS) begin : g_fsel
      always_comb begin
        fsel_d[g] = fsel_q[g];
        if (fsel_wr && (dec_i.fsel_idx == 3'(Reg))) begin
          fsel_d[g] = write_data_i[Lsb +: gscl_pkg::FN_W];
        end
      end
    end else begin : g_nofsel
      // Pins beyond the function-select map stay inputs.
      assign fsel_d[g] = fsel_q[g];
    end
  end

  // Read words of the function-select registers; missing pins read 0.
  for (genvar r = 0; r < gscl_pkg::FSEL_REGS; r++) begin : g_word
    for (genvar k = 0; k < gscl_pkg::PINS_PER_FSEL; k++) begin : g_field
      localparam int unsigned Pin = r * gscl_pkg::PINS_PER_FSEL + k;
      if (Pin < PIN_COUNT) begin : g_live
        assign fsel_word[r][gscl_pkg::FN_W*k +: gscl_pkg::FN_W] = fsel_q[Pin];
      end else begin : g_dead
        assign fsel_word[r][gscl_pkg::FN_W*k +: gscl_pkg::FN_W] = '0;
      end
    end
    assign fsel_word[r][gscl_pkg::DATA_W-1:gscl_pkg::FN_W*gscl_pkg::PINS_PER_FSEL] = '0;
  end

  // Place bank data into the pin vector; bank 1 drops bits past the last pin.
  assign val_wide = dec_i.bank ? {write_data_i, {gscl_pkg::BANK_BITS{1'b0}}}
                               : {{gscl_pkg::BANK_BITS{1'b0}}, write_data_i};
  assign val      = val_wide[PIN_COUNT-1:0];

  // Level and drive update for SET, CLR and pin events.
  always_comb begin
    lev_d   = lev_q;
    drive_d = drive_q;
    if (en_i && is_wr && (dec_i.kind == gscl_pkg::REG_SET)) begin
      drive_d = drive_q | (val & ~lev_q & out_mask);
      lev_d   = lev_q | val;
    end else if (en_i && is_wr && (dec_i.kind == gscl_pkg::REG_CLR)) begin
      drive_d = drive_q & ~(val & lev_q & out_mask);
      lev_d   = lev_q & ~val;
    end else if (en_i && is_ev) begin
      lev_d = (lev_q & ~(pin_hit & in_mask)) |
              ((pin_hit & in_mask) & {PIN_COUNT{pin_value_i}});
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= '{default: '0};
      lev_q   <= '0;
      drive_q <= '0;
    end else begin
      fsel_q  <= fsel_d;
      lev_q   <= lev_d;
      drive_q <= drive_d;
    end
  end

  // Read data and error flag from the state before this beat.
  assign lev_wide = WideW'(lev_q);
  always_comb begin
    read_data_o = '0;
    bus_error_o = 1'b0;
    if (is_rd || is_wr) begin
      case (dec_i.kind)
        gscl_pkg::REG_FSEL: begin
          if (is_rd && (dec_i.fsel_idx < 3'(gscl_pkg::FSEL_REGS))) begin
            read_data_o = fsel_word[dec_i.fsel_idx];
          end
        end
        gscl_pkg::REG_LEV: begin
          if (is_rd) begin
            read_data_o = dec_i.bank ? lev_wide[WideW-1:gscl_pkg::BANK_BITS]
                                     : lev_wide[gscl_pkg::BANK_BITS-1:0];
          end
        end
        gscl_pkg::REG_BAD: bus_error_o = 1'b1;
        default: read_data_o = '0;
      endcase
    end
  end

  // Drive levels after this beat, truncated to the result field.
  assign drive_wide  = WideW'(drive_d);
  assign pin_drive_o = drive_wide[gscl_pkg::DRIVE_W-1:0];

endmodule

// ===== design/gpio_set_clear_level_regs_top.sv =====
// A result beat is valid once its request beat has been accepted and has passed
// the input register and then the result register.
// Throughput: one beat per cycle; the input and result registers stall together
// only while the result register is full and not taken.
// All state updates happen in the single compute stage, so each beat sees the last.
// Reset: pins all inputs, level and drive registers zero, both stages empty.
module gpio_set_clear_level_regs_top #(
  parameter int unsigned PIN_COUNT = 54
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gscl_in_if.sink    in_i,
  gscl_out_if.source out_o
);

  logic                           in_vq;
  logic [1:0]                     op_q;
  logic [gscl_pkg::OFS_W-1:0]     ofs_q;
  logic [gscl_pkg::DATA_W-1:0]    data_q;
  logic [gscl_pkg::PIN_W-1:0]     pin_q;
  logic                           pval_q;
  logic                           out_vq;
  logic [gscl_pkg::DATA_W-1:0]    rd_q, rd_d;
  logic                           err_q, err_d;
  logic [gscl_pkg::DRIVE_W-1:0]   drive_q, drive_d;
  logic                           adv;
  gscl_pkg::dec_t                 dec;

  // The pipeline moves whenever the result register is free or being taken.
  assign adv      = !out_vq || out_o.ready;
  assign in_i.ready = !in_vq || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.op;
      ofs_q  <= in_i.offset;
      data_q <= in_i.write_data;
      pin_q  <= in_i.pin_index;
      pval_q <= in_i.pin_value;
    end
  end

  gscl_decode u_decode (
    .offset_i (ofs_q),
    .dec_o    (dec)
  );

  gscl_core #(
    .PIN_COUNT (PIN_COUNT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (in_vq && adv),
    .op_i         (op_q),
    .dec_i        (dec),
    .write_data_i (data_q),
    .pin_index_i  (pin_q),
    .pin_value_i  (pval_q),
    .read_data_o  (rd_d),
    .bus_error_o  (err_d),
    .pin_drive_o  (drive_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= in_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vq && adv) begin
      rd_q    <= rd_d;
      err_q   <= err_d;
      drive_q <= drive_d;
    end
  end

  assign out_o.valid     = out_vq;
  assign out_o.read_data = rd_q;
  assign out_o.bus_error = err_q;
  assign out_o.pin_drive = drive_q;

  // An error beat never carries read data.
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && err_q |-> rd_q == '0)
    else $error("bus error beat carries read data");

  // A beat leaving the input stage always lands in the result register.
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && adv |=> out_vq)
    else $error("beat lost between stages");

  // Pin events never produce read data or an error.
  a_event_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && adv && (op_q == gscl_pkg::OP_EVENT) |=> (rd_q == '0) && !err_q)
    else $error("pin event produced bus response");

endmodule

// ===== tb/tb_gpio_set_clear_level_regs_top.sv =====
module tb_gpio_set_clear_level_regs_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PINS        = 54;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned RAND_ITEMS  = 400;

  // Op code that the block must treat as a no-op.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Offsets outside the register map.
  localparam logic [gscl_pkg::OFS_W-1:0] OFS_GAP       = 8'h18;
  localparam logic [gscl_pkg::OFS_W-1:0] OFS_MISALIGN  = 8'h01;
  localparam logic [gscl_pkg::OFS_W-1:0] OFS_PAST_MAP  = 8'hA0;
  localparam logic [gscl_pkg::OFS_W-1:0] OFS_TOP       = 8'hFF;

  // Bank 1 carries only the pins above bit 31.
  localparam logic [gscl_pkg::DATA_W-1:0] BANK1_MASK = 32'hFFFF_FFFF >> (64 - PINS);

  // Every function field set to output, and all fields for a partial register.
  localparam logic [gscl_pkg::DATA_W-1:0] FSEL_ALL_OUT  = 32'h0924_9249;
  localparam logic [gscl_pkg::DATA_W-1:0] FSEL_LOW4_OUT = 32'h0000_0249;

  typedef struct {
    logic [gscl_pkg::DATA_W-1:0]  read_data;
    logic                         bus_error;
    logic [gscl_pkg::DRIVE_W-1:0] pin_drive;
  } gpio_resp_t;

  // Mirror of the register block and the responses it owes.
  class gpio_reg_mirror;
    logic [gscl_pkg::FN_W-1:0] pin_fn [PINS];
    logic [PINS-1:0]           level;
    logic [PINS-1:0]           drive;
    gpio_resp_t                due_responses [$];
    int unsigned               failures;

    function new();
      foreach (pin_fn[i]) pin_fn[i] = gscl_pkg::FN_INPUT;
      level    = '0;
      drive    = '0;
      failures = 0;
    endfunction

    function logic [PINS-1:0] output_pins();
      logic [PINS-1:0] m;
      m = '0;
      foreach (pin_fn[i]) if (pin_fn[i] == gscl_pkg::FN_OUTPUT) m[i] = 1'b1;
      return m;
    endfunction

    function logic [gscl_pkg::DATA_W-1:0] fsel_word(int unsigned idx);
      logic [gscl_pkg::DATA_W-1:0] v;
      int unsigned pin;
      v = '0;
      for (int k = 0; k < gscl_pkg::PINS_PER_FSEL; k++) begin
        pin = idx * gscl_pkg::PINS_PER_FSEL + k;
        if (pin < PINS) v[3*k +: 3] = pin_fn[pin];
      end
      return v;
    endfunction

    function void fsel_store(int unsigned idx, logic [gscl_pkg::DATA_W-1:0] data);
      int unsigned pin;
      for (int k = 0; k < gscl_pkg::PINS_PER_FSEL; k++) begin
        pin = idx * gscl_pkg::PINS_PER_FSEL + k;
        if (pin < PINS) pin_fn[pin] = data[3*k +: 3];
      end
    endfunction

    function logic [PINS-1:0] bank_vec(logic bank, logic [gscl_pkg::DATA_W-1:0] data);
      if (!bank) return PINS'(data);
      return PINS'(64'(data & BANK1_MASK) << gscl_pkg::BANK_BITS);
    endfunction

    function bit is_unimplemented(logic [gscl_pkg::OFS_W-1:0] ofs);
      foreach (gscl_pkg::UNIMP_OFS[i]) if (gscl_pkg::UNIMP_OFS[i] == ofs) return 1'b1;
      return 1'b0;
    endfunction

    // Apply one accepted request beat and queue the response it causes.
    function void note_request(logic [1:0] op, logic [gscl_pkg::OFS_W-1:0] ofs,
                               logic [gscl_pkg::DATA_W-1:0] data,
                               logic [gscl_pkg::PIN_W-1:0] pin, logic pval);
      gpio_resp_t      r;
      logic [PINS-1:0] vec;
      bit              wr;
      r.read_data = '0;
      r.bus_error = 1'b0;
      if (op == gscl_pkg::OP_READ || op == gscl_pkg::OP_WRITE) begin
        wr = (op == gscl_pkg::OP_WRITE);
        if (ofs < gscl_pkg::OFS_FSEL_END && ofs[1:0] == 2'b00) begin
          if (wr) fsel_store(ofs >> 2, data);
          else r.read_data = fsel_word(ofs >> 2);
        end else if (ofs == gscl_pkg::OFS_SET0 || ofs == gscl_pkg::OFS_SET1) begin
          if (wr) begin
            // A set makes an output pin drive high only where its level rises.
            vec   = bank_vec(ofs == gscl_pkg::OFS_SET1, data);
            drive = drive | (vec & ~level & output_pins());
            level = level | vec;
          end
        end else if (ofs == gscl_pkg::OFS_CLR0 || ofs == gscl_pkg::OFS_CLR1) begin
          if (wr) begin
            // A clear drops the drive of an output pin whose level was high.
            vec   = bank_vec(ofs == gscl_pkg::OFS_CLR1, data);
            drive = drive & ~(vec & level & output_pins());
            level = level & ~vec;
          end
        end else if (ofs == gscl_pkg::OFS_LEV0) begin
          if (!wr) r.read_data = level[31:0];
        end else if (ofs == gscl_pkg::OFS_LEV1) begin
          if (!wr) begin
            r.read_data = gscl_pkg::DATA_W'(level >> gscl_pkg::BANK_BITS) & BANK1_MASK;
          end
        end else if (!is_unimplemented(ofs)) begin
          r.bus_error = 1'b1;
        end
      end else if (op == gscl_pkg::OP_EVENT) begin
        // External level changes only land on pins configured as inputs.
        if (pin < PINS && pin_fn[pin] == gscl_pkg::FN_INPUT) level[pin] = pval;
      end
      r.pin_drive = gscl_pkg::DRIVE_W'(drive);
      due_responses.push_back(r);
    endfunction

    // Compare one accepted response beat with the oldest owed response.
    function void check_response(logic [gscl_pkg::DATA_W-1:0] rd, logic err,
                                 logic [gscl_pkg::DRIVE_W-1:0] drv);
      gpio_resp_t e;
      if (due_responses.size() == 0) begin
        $display("%0t: response beat with none owed: read_data %h bus_error %b pin_drive %h",
                 $time, rd, err, drv);
        failures++;
        return;
      end
      e = due_responses.pop_front();
      if (rd !== e.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, rd);
        failures++;
      end
      if (err !== e.bus_error) begin
        $display("%0t: bus_error expected %b actual %b", $time, e.bus_error, err);
        failures++;
      end
      if (drv !== e.pin_drive) begin
        $display("%0t: pin_drive expected %h actual %h", $time, e.pin_drive, drv);
        failures++;
      end
    endfunction

    function void flag_leftovers();
      foreach (due_responses[i])
        $display("%0t: response never arrived: read_data expected %h bus_error %b pin_drive %h",
                 $time, due_responses[i].read_data, due_responses[i].bus_error,
                 due_responses[i].pin_drive);
      failures += due_responses.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;

  gscl_in_if  req_if ();
  gscl_out_if rsp_if ();

  gpio_reg_mirror mirror;

  gpio_set_clear_level_regs_top #(
    .PIN_COUNT (PINS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("gpio_set_clear_level_regs_top verification failed");
    $finish;
  end

  // Response side: ready drops at random except during the steady stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        mirror.note_request(req_if.op, req_if.offset, req_if.write_data,
                            req_if.pin_index, req_if.pin_value);
      if (rsp_if.valid && rsp_if.ready)
        mirror.check_response(rsp_if.read_data, rsp_if.bus_error, rsp_if.pin_drive);
    end
  end

  // Drive one request beat and hold it until it is taken.
  task automatic send_beat(input logic [1:0] op, input logic [gscl_pkg::OFS_W-1:0] ofs,
                           input logic [gscl_pkg::DATA_W-1:0] data,
                           input logic [gscl_pkg::PIN_W-1:0] pin, input logic pval);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.offset     <= ofs;
    req_if.write_data <= data;
    req_if.pin_index  <= pin;
    req_if.pin_value  <= pval;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [gscl_pkg::OFS_W-1:0] ofs,
                           input logic [gscl_pkg::DATA_W-1:0] data);
    send_beat(gscl_pkg::OP_WRITE, ofs, data, gscl_pkg::PIN_W'($urandom), 1'($urandom));
  endtask

  task automatic reg_read(input logic [gscl_pkg::OFS_W-1:0] ofs);
    send_beat(gscl_pkg::OP_READ, ofs, $urandom, gscl_pkg::PIN_W'($urandom), 1'($urandom));
  endtask

  task automatic pin_event(input logic [gscl_pkg::PIN_W-1:0] pin, input logic pval);
    send_beat(gscl_pkg::OP_EVENT, gscl_pkg::OFS_W'($urandom), $urandom, pin, pval);
  endtask

  // Function-select word that mostly picks input or output, sometimes anything.
  function automatic logic [gscl_pkg::DATA_W-1:0] fsel_pattern();
    logic [gscl_pkg::DATA_W-1:0] w;
    int unsigned                 pick;
    w = $urandom;
    for (int k = 0; k < gscl_pkg::PINS_PER_FSEL; k++) begin
      pick = $urandom_range(9);
      if (pick < 4) w[3*k +: 3] = gscl_pkg::FN_INPUT;
      else if (pick < 8) w[3*k +: 3] = gscl_pkg::FN_OUTPUT;
    end
    return w;
  endfunction

  // Offset of one of the function-select registers.
  function automatic logic [gscl_pkg::OFS_W-1:0] fsel_offset();
    return gscl_pkg::OFS_W'(4 * $urandom_range(gscl_pkg::FSEL_REGS - 1));
  endfunction

  // Any offset that decodes to a known register.
  function automatic logic [gscl_pkg::OFS_W-1:0] known_offset();
    case ($urandom_range(5))
      0: return fsel_offset();
      1: return $urandom_range(1) ? gscl_pkg::OFS_SET1 : gscl_pkg::OFS_SET0;
      2: return $urandom_range(1) ? gscl_pkg::OFS_CLR1 : gscl_pkg::OFS_CLR0;
      3, 4: return $urandom_range(1) ? gscl_pkg::OFS_LEV1 : gscl_pkg::OFS_LEV0;
      default: return gscl_pkg::UNIMP_OFS[$urandom_range(gscl_pkg::UNIMP_COUNT - 1)];
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    mirror = new();
    steady = 1'b0;
    req_if.valid      = 1'b0;
    req_if.op         = gscl_pkg::OP_READ;
    req_if.offset     = '0;
    req_if.write_data = '0;
    req_if.pin_index  = '0;
    req_if.pin_value  = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset values, field extremes, bank widths and decode corners.
    reg_read(8'h00);
    reg_write(8'h00, 32'hFFFF_FFFF);
    reg_read(8'h00);
    reg_write(8'h00, FSEL_ALL_OUT);
    reg_write(8'h14, 32'hFFFF_FFFF);
    reg_read(8'h14);
    reg_write(8'h14, FSEL_LOW4_OUT);
    reg_write(gscl_pkg::OFS_SET0, 32'hFFFF_FFFF);
    reg_write(gscl_pkg::OFS_SET1, 32'hFFFF_FFFF);
    reg_read(gscl_pkg::OFS_LEV0);
    reg_read(gscl_pkg::OFS_LEV1);
    reg_read(gscl_pkg::OFS_SET0);
    reg_read(gscl_pkg::OFS_CLR1);
    reg_write(gscl_pkg::OFS_LEV0, 32'h0000_0000);
    reg_write(gscl_pkg::OFS_CLR0, 32'h0000_0005);
    reg_write(8'h00, 32'h0000_0000);
    pin_event(6'd0, 1'b1);
    pin_event(6'd50, 1'b0);
    pin_event(6'd63, 1'b1);
    send_beat(OP_NONE, gscl_pkg::OFS_SET0, 32'hFFFF_FFFF, 6'd53, 1'b1);
    reg_read(gscl_pkg::UNIMP_OFS[0]);
    reg_write(gscl_pkg::UNIMP_OFS[gscl_pkg::UNIMP_COUNT - 1], 32'hFFFF_FFFF);
    reg_read(OFS_GAP);
    reg_read(OFS_MISALIGN);
    reg_write(OFS_PAST_MAP, 32'hFFFF_FFFF);
    reg_read(OFS_TOP);
    reg_write(gscl_pkg::OFS_CLR1, 32'hFFFF_FFFF);

    // Random: mostly well-formed accesses, with events and decode noise.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady = (n >= 150 && n < 240);
      pick = $urandom_range(99);
      if (pick < 20) reg_write(fsel_offset(), fsel_pattern());
      else if (pick < 34)
        reg_write($urandom_range(1) ? gscl_pkg::OFS_SET1 : gscl_pkg::OFS_SET0, $urandom);
      else if (pick < 46)
        reg_write($urandom_range(1) ? gscl_pkg::OFS_CLR1 : gscl_pkg::OFS_CLR0, $urandom);
      else if (pick < 66) reg_read(known_offset());
      else if (pick < 82)
        pin_event(gscl_pkg::PIN_W'($urandom_range(PINS - 1)), 1'($urandom));
      else if (pick < 86) pin_event(gscl_pkg::PIN_W'($urandom), 1'($urandom));
      else if (pick < 90) reg_write(known_offset(), $urandom);
      else if (pick < 96)
        send_beat(2'($urandom_range(1)), gscl_pkg::OFS_W'($urandom), $urandom,
                  gscl_pkg::PIN_W'($urandom), 1'($urandom));
      else
        send_beat(OP_NONE, gscl_pkg::OFS_W'($urandom), $urandom,
                  gscl_pkg::PIN_W'($urandom), 1'($urandom));
    end
    steady = 1'b0;
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain the owed responses, then give the pipeline time to show extras.
    while (mirror.due_responses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    mirror.flag_leftovers();
    if (mirror.failures == 0) begin
      $display("gpio_set_clear_level_regs_top verification clean");
    end else begin
      $display("gpio_set_clear_level_regs_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gscl_pkg.sv
design/gscl_if.sv
design/gscl_decode.sv
design/gscl_core.sv
design/gpio_set_clear_level_regs_top.sv
tb/tb_gpio_set_clear_level_regs_top.sv
